FILE: hdl/rsbs_pkg.sv
// Shared types, constants and helpers for the recency-sorted budget selector.
// No dependencies; every other file of the block refers to this package.
package rsbs_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int ID_W            = 8;
    localparam int SIZE_W          = 48;
    localparam int TIME_W          = 63;
    localparam int PSHIFT_W        = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 48;

    localparam logic [PSHIFT_W-1:0] PAGE_SHIFT_RST = PSHIFT_W'(12);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUDGET     = 2'd0,
        CFG_ONLINE     = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_PAGE_SHIFT = 2'd3
    } cfg_idx_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK
    } state_t;

    // One stored region
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] acc_time;
    } entry_t;

    // Region handed from the sorter to the selection stage
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic              last;
    } pick_t;

    // Configuration register contents
    typedef struct packed {
        logic [SIZE_W-1:0]   budget;
        logic                online;
        logic [SIZE_W-1:0]   threshold;
        logic [PSHIFT_W-1:0] page_shift;
    } cfg_t;

    // Round a size up to a whole number of pages; keeps the carry bit
    function automatic logic [SIZE_W:0] align_up(input logic [SIZE_W-1:0] size,
                                                 input logic [PSHIFT_W-1:0] shift);
        logic [SIZE_W:0] mask;
        mask = {(SIZE_W+1){1'b1}} << shift;
        return ({1'b0, size} + ~mask) & mask;
    endfunction

endpackage

FILE: hdl/rsbs_if.sv
// Valid/ready channel interfaces for region items and result items.
// Depends on rsbs_pkg for field widths.
interface rsbs_in_if;
    logic                          valid;
    logic                          ready;
    logic [rsbs_pkg::ID_W-1:0]     region_id;
    logic [rsbs_pkg::SIZE_W-1:0]   region_size;
    logic [rsbs_pkg::TIME_W-1:0]   access_time_us;
    logic                          final_region;

    modport source (output valid, region_id, region_size, access_time_us, final_region,
                    input ready);
    modport sink   (input valid, region_id, region_size, access_time_us, final_region,
                    output ready);
endinterface

interface rsbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [rsbs_pkg::ID_W-1:0]     out_region_id;
    logic                          selected;
    logic [rsbs_pkg::SIZE_W-1:0]   rounded_size;
    logic                          end_of_list;

    modport source (output valid, out_region_id, selected, rounded_size, end_of_list,
                    input ready);
    modport sink   (input valid, out_region_id, selected, rounded_size, end_of_list,
                    output ready);
endinterface

FILE: hdl/rsbs_entry_mem.sv
// Region store: one write port, one read port, registered read data.
// Depends on rsbs_pkg for the entry type.
module rsbs_entry_mem #(
    parameter int DEPTH = rsbs_pkg::MAX_REGIONS_DEF
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  rsbs_pkg::entry_t           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output rsbs_pkg::entry_t           rdata
);

    rsbs_pkg::entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/rsbs_ctrl.sv
// Load and sort controller: stores regions, then scans the store once per
// output slot to find the most recent unused entry. Depends on rsbs_pkg,
// rsbs_if and drives an rsbs_entry_mem instance through its ports.
module rsbs_ctrl #(
    parameter int MAX_REGIONS = rsbs_pkg::MAX_REGIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rsbs_in_if.sink                          in_ch,
    input  logic                             sel_idle,
    output logic                             start,
    output logic                             mem_we,
    output logic [$clog2(MAX_REGIONS)-1:0]   mem_waddr,
    output rsbs_pkg::entry_t                 mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(MAX_REGIONS)-1:0]   mem_raddr,
    input  rsbs_pkg::entry_t                 mem_rdata,
    output rsbs_pkg::pick_t                  pick,
    input  logic                             pick_ready
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    rsbs_pkg::state_t        state_reg, state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        scan_addr_reg;
    logic [CNT_W-1:0]        emit_cnt_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [MAX_REGIONS-1:0]  used_reg;
    logic                    best_vld_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    rsbs_pkg::entry_t        best_reg;

    logic load_acc;
    logic store;
    logic issue;
    logic scan_done;
    logic hit;
    logic pick_acc;
    logic last_pick;

    assign load_acc  = in_ch.valid && in_ch.ready;
    assign store     = load_acc && (count_reg < CNT_MAX);
    assign issue     = (state_reg == rsbs_pkg::ST_SCAN) && (scan_addr_reg < count_reg);
    assign scan_done = (state_reg == rsbs_pkg::ST_SCAN) && !issue && !rd_vld_reg;
    // Strictly greater keeps the earliest-loaded entry among equal times
    assign hit       = rd_vld_reg && !used_reg[rd_idx_reg] &&
                       (!best_vld_reg || (mem_rdata.acc_time > best_reg.acc_time));
    assign pick_acc  = (state_reg == rsbs_pkg::ST_PICK) && pick_ready;
    assign last_pick = (emit_cnt_reg == CNT_W'(count_reg - CNT_ONE));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsbs_pkg::ST_LOAD:
            begin
                if (load_acc && in_ch.final_region)
                begin
                    state_next = rsbs_pkg::ST_SCAN;
                end
            end
            rsbs_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = rsbs_pkg::ST_PICK;
                end
            end
            rsbs_pkg::ST_PICK:
            begin
                if (pick_acc)
                begin
                    state_next = last_pick ? rsbs_pkg::ST_LOAD : rsbs_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = rsbs_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ch.ready       = (state_reg == rsbs_pkg::ST_LOAD) && sel_idle;
        start             = load_acc && in_ch.final_region;
        mem_we            = store;
        mem_waddr         = count_reg[IDX_W-1:0];
        mem_wdata.id       = in_ch.region_id;
        mem_wdata.size     = in_ch.region_size;
        mem_wdata.acc_time = in_ch.access_time_us;
        mem_re            = issue;
        mem_raddr         = scan_addr_reg[IDX_W-1:0];
        pick.valid        = (state_reg == rsbs_pkg::ST_PICK);
        pick.id           = best_reg.id;
        pick.size         = best_reg.size;
        pick.last         = last_pick;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsbs_pkg::ST_LOAD;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            emit_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            used_reg      <= '0;
            best_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;

            // Count stored regions; drop loads past the end
            if (store)
            begin
                count_reg <= count_reg + CNT_ONE;
            end

            // Start the first scan pass
            if (load_acc && in_ch.final_region)
            begin
                scan_addr_reg <= '0;
                emit_cnt_reg  <= '0;
                best_vld_reg  <= 1'b0;
            end

            // Advance the read address
            if (issue)
            begin
                scan_addr_reg <= scan_addr_reg + CNT_ONE;
            end

            if (hit)
            begin
                best_vld_reg <= 1'b1;
            end

            // Retire the picked entry and start the next pass, or end the run
            if (pick_acc)
            begin
                scan_addr_reg <= '0;
                best_vld_reg  <= 1'b0;
                emit_cnt_reg  <= emit_cnt_reg + CNT_ONE;
                if (last_pick)
                begin
                    count_reg <= '0;
                    used_reg  <= '0;
                end
                else
                begin
                    used_reg[best_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Scan payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
        if (hit)
        begin
            best_reg     <= mem_rdata;
            best_idx_reg <= rd_idx_reg;
        end
    end

endmodule

FILE: hdl/rsbs_select.sv
// Budget selection: aligns each picked region, applies threshold and budget,
// and holds the result item in an output register. Depends on rsbs_pkg, rsbs_if.
module rsbs_select (
    input  logic              clk,
    input  logic              rst_n,
    input  rsbs_pkg::cfg_t    cfg,
    input  logic              start,
    input  rsbs_pkg::pick_t   pick,
    output logic              pick_ready,
    output logic              idle,
    rsbs_out_if.source        out_ch
);

    localparam int SW = rsbs_pkg::SIZE_W;

    logic                          s1_vld_reg;
    logic [rsbs_pkg::ID_W-1:0]     s1_id_reg;
    logic [SW:0]                   s1_aligned_reg;
    logic                          s1_elig_reg;
    logic                          s1_last_reg;
    logic [SW-1:0]                 rem_reg;

    logic                          out_vld_reg;
    logic [rsbs_pkg::ID_W-1:0]     out_id_reg;
    logic                          out_sel_reg;
    logic [SW-1:0]                 out_size_reg;
    logic                          out_last_reg;

    logic take;
    logic fire;
    logic chosen;

    assign pick_ready = !s1_vld_reg;
    assign idle       = !s1_vld_reg;
    assign take       = pick.valid && !s1_vld_reg;
    assign fire       = s1_vld_reg && (!out_vld_reg || out_ch.ready);
    assign chosen     = s1_elig_reg && (s1_aligned_reg < {1'b0, rem_reg});

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.out_region_id = out_id_reg;
    assign out_ch.selected      = out_sel_reg;
    assign out_ch.rounded_size  = out_size_reg;
    assign out_ch.end_of_list   = out_last_reg;

    // Control: stage valid, output valid, remaining budget
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            rem_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_vld_reg <= 1'b0;
            end

            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            // Load the budget (halved if online) at run start, spend it per choice
            if (start)
            begin
                rem_reg <= cfg.online ? (cfg.budget >> 1) : cfg.budget;
            end
            else if (fire && chosen)
            begin
                rem_reg <= rem_reg - s1_aligned_reg[SW-1:0];
            end
        end
    end

    // Align and check the threshold
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_id_reg      <= pick.id;
            s1_aligned_reg <= rsbs_pkg::align_up(pick.size, cfg.page_shift);
            s1_elig_reg    <= (pick.size >= cfg.threshold);
            s1_last_reg    <= pick.last;
        end
    end

    // Hold the result item; saturate the reported size
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_id_reg   <= s1_id_reg;
            out_sel_reg  <= chosen;
            out_size_reg <= s1_aligned_reg[SW] ? {SW{1'b1}} : s1_aligned_reg[SW-1:0];
            out_last_reg <= s1_last_reg;
        end
    end

endmodule

FILE: hdl/recency_sorted_budget_selector_top.sv
// Recency-sorted budget selector, top level: configuration registers and
// the controller, entry memory and selection stage.
// Depends on rsbs_pkg, rsbs_if, rsbs_entry_mem, rsbs_ctrl and rsbs_select.
//
// Usage: region items arrive on in_ch, one per cycle while the block loads
// and holds in_ch ready. Each item is stored; loads past MAX_REGIONS are
// dropped. An item with final_region set ends the load phase. The block then
// emits one result item per stored region on out_ch, most recently accessed
// first (equal times in load order), with selected set for regions that
// meet the threshold and fit the budget. With n stored regions the output
// phase runs n scan passes over the single read port of the entry memory;
// in_ch is not ready until the last result item of the run has moved into
// the output register. Results sit in an output register: when out_ch
// stalls the block holds the item and the pipeline behind it waits.
// The user must write configuration (cfg_we, cfg_index, cfg_wdata) only
// while idle; the block itself does not enforce it.
// Reset clears the region count, the remaining budget and the configuration
// (page_shift returns to 12). The entry memory is not cleared; only entries
// written in the current run are ever read.
module recency_sorted_budget_selector_top #(
    parameter int MAX_REGIONS = rsbs_pkg::MAX_REGIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rsbs_in_if.sink                             in_ch,
    rsbs_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [rsbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_REGIONS);

    rsbs_pkg::cfg_t     cfg_reg;
    logic               sel_idle;
    logic               start;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    rsbs_pkg::entry_t   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    rsbs_pkg::entry_t   mem_rdata;
    rsbs_pkg::pick_t    pick;
    logic               pick_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.budget     <= '0;
            cfg_reg.online     <= 1'b0;
            cfg_reg.threshold  <= '0;
            cfg_reg.page_shift <= rsbs_pkg::PAGE_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (rsbs_pkg::cfg_idx_t'(cfg_index))
                rsbs_pkg::CFG_BUDGET:
                begin
                    cfg_reg.budget <= cfg_wdata[rsbs_pkg::SIZE_W-1:0];
                end
                rsbs_pkg::CFG_ONLINE:
                begin
                    cfg_reg.online <= cfg_wdata[0];
                end
                rsbs_pkg::CFG_THRESHOLD:
                begin
                    cfg_reg.threshold <= cfg_wdata[rsbs_pkg::SIZE_W-1:0];
                end
                rsbs_pkg::CFG_PAGE_SHIFT:
                begin
                    cfg_reg.page_shift <= cfg_wdata[rsbs_pkg::PSHIFT_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    rsbs_ctrl #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .sel_idle   (sel_idle),
        .start      (start),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .pick       (pick),
        .pick_ready (pick_ready)
    );

    rsbs_entry_mem #(
        .DEPTH (MAX_REGIONS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsbs_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (start),
        .pick       (pick),
        .pick_ready (pick_ready),
        .idle       (sel_idle),
        .out_ch     (out_ch)
    );

endmodule

FILE: dv/tb.sv
// Testbench for recency_sorted_budget_selector_top: directed table, then random region runs.
// Checks every result item against a built-in model of the sort and budget walk.
// Depends on rsbs_pkg, rsbs_in_if, rsbs_out_if and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_REGIONS    = rsbs_pkg::MAX_REGIONS_DEF;
    localparam logic [47:0] MAX48          = {48{1'b1}};
    localparam logic [62:0] MAX63          = {63{1'b1}};
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          RANDOM_ITEMS   = 180;

    typedef enum logic {ROW_REGION, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        rsbs_pkg::cfg_idx_t          reg_sel;
        logic [47:0]                 value;
        logic [rsbs_pkg::ID_W-1:0]   id;
        logic [rsbs_pkg::SIZE_W-1:0] size;
        logic [rsbs_pkg::TIME_W-1:0] acc;
        logic                        fin;
        logic                        typed;
        logic                        t_sel;
        logic [rsbs_pkg::SIZE_W-1:0] t_rsize;
    } plan_row_t;

    typedef struct packed {
        logic [rsbs_pkg::ID_W-1:0]   id;
        logic                        sel;
        logic [rsbs_pkg::SIZE_W-1:0] rsize;
        logic                        eol;
    } region_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rsbs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rsbs_pkg::CFG_DATA_W-1:0] cfg_wdata;

    rsbs_in_if  in_ch ();
    rsbs_out_if out_ch ();

    recency_sorted_budget_selector_top #(
        .MAX_REGIONS (MAX_REGIONS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the block: stored regions and register settings
    logic [rsbs_pkg::ID_W-1:0]   tbl_id   [MAX_REGIONS];
    logic [rsbs_pkg::SIZE_W-1:0] tbl_size [MAX_REGIONS];
    logic [rsbs_pkg::TIME_W-1:0] tbl_time [MAX_REGIONS];
    int                          tbl_count;
    logic [rsbs_pkg::SIZE_W-1:0] cur_budget;
    logic                        cur_online;
    logic [rsbs_pkg::SIZE_W-1:0] cur_threshold;
    logic [4:0]                  cur_shift;

    region_result_t    due_results[$];
    plan_row_t         plan[$];
    int                mismatches;
    bit                hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [47:0] masked48(input int bits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0] & ((48'd1 << bits) - 48'd1);
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic plan_row_t region_row(input logic [7:0] id, input logic [47:0] size,
                                             input logic [62:0] acc, input logic fin);
        plan_row_t r;
        r = '0;
        r.kind = ROW_REGION;
        r.id   = id;
        r.size = size;
        r.acc  = acc;
        r.fin  = fin;
        return r;
    endfunction

    // Single-region run whose result is written out by hand
    function automatic plan_row_t last_row(input logic [7:0] id, input logic [47:0] size,
                                           input logic [62:0] acc, input logic sel,
                                           input logic [47:0] rsize);
        plan_row_t r;
        r = region_row(id, size, acc, 1'b1);
        r.typed   = 1'b1;
        r.t_sel   = sel;
        r.t_rsize = rsize;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input rsbs_pkg::cfg_idx_t idx,
                                          input logic [47:0] value);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = idx;
        r.value   = value;
        return r;
    endfunction

    // Store a region; on the last one rank by recency and walk the budget
    task automatic rank_regions(input logic [7:0] id, input logic [47:0] size,
                                input logic [62:0] acc, input logic fin);
        int             order [MAX_REGIONS];
        int             n;
        int             cur;
        int             j;
        int             e;
        logic [63:0]    left;
        logic [63:0]    page;
        logic [63:0]    aligned;
        logic           pick;
        region_result_t res;
        if (tbl_count < MAX_REGIONS)
        begin
            tbl_id[tbl_count]   = id;
            tbl_size[tbl_count] = size;
            tbl_time[tbl_count] = acc;
            tbl_count++;
        end
        if (!fin)
            return;
        n = tbl_count;
        for (int i = 0; i < n; i++)
            order[i] = i;
        // stable insertion sort, newest access first
        for (int i = 1; i < n; i++)
        begin
            cur = order[i];
            j = i;
            while (j > 0 && tbl_time[order[j-1]] < tbl_time[cur])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        left = {16'd0, cur_budget};
        if (cur_online)
            left = left / 2;
        page = 64'd1 << cur_shift;
        for (int i = 0; i < n; i++)
        begin
            e = order[i];
            aligned = ({16'd0, tbl_size[e]} + page - 64'd1) & ~(page - 64'd1);
            pick = (aligned < left) && (tbl_size[e] >= cur_threshold);
            if (pick)
                left = left - aligned;
            res.id    = tbl_id[e];
            res.sel   = pick;
            res.rsize = (aligned > {16'd0, MAX48}) ? MAX48 : aligned[47:0];
            res.eol   = (i == n - 1);
            due_results.push_back(res);
        end
        tbl_count = 0;
    endtask

    // Offer one region after a gap and hold it until accepted
    task automatic send_region(input logic [7:0] id, input logic [47:0] size,
                               input logic [62:0] acc, input logic fin, input int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.region_id      <= id;
        in_ch.region_size    <= size;
        in_ch.access_time_us <= acc;
        in_ch.final_region   <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        rank_regions(id, size, acc, fin);
    endtask

    // Drop valid and wait for every due result, then let the block settle
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input rsbs_pkg::cfg_idx_t idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            rsbs_pkg::CFG_BUDGET:     cur_budget    = value;
            rsbs_pkg::CFG_ONLINE:     cur_online    = value[0];
            rsbs_pkg::CFG_THRESHOLD:  cur_threshold = value;
            rsbs_pkg::CFG_PAGE_SHIFT: cur_shift     = value[4:0];
            default:                  ;
        endcase
    endtask

    // Receiver: random ready stretches, plus one long hold-off on request
    initial
    begin
        int  run_left;
        int  hold_left;
        bit  rdy_now;
        run_left  = 0;
        hold_left = 0;
        rdy_now   = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy_now = 1'b0;
            end
            else if (run_left == 0)
            begin
                rdy_now = !rdy_now;
                if (rdy_now)
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 100)
                                                          : $urandom_range(1, 8);
                else
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
            else
                run_left--;
            out_ch.ready <= rdy_now;
        end
    end

    // Compare each result item with the oldest one due
    always @(posedge clk)
    begin : result_check
        region_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (due_results.size() == 0)
                report($sformatf("result item id %0h with nothing due", out_ch.out_region_id));
            else
            begin
                want = due_results.pop_front();
                if (out_ch.out_region_id !== want.id)
                    report($sformatf("out_region_id %0h, want %0h",
                                     out_ch.out_region_id, want.id));
                if (out_ch.selected !== want.sel)
                    report($sformatf("selected %0b, want %0b (id %0h)",
                                     out_ch.selected, want.sel, want.id));
                if (out_ch.rounded_size !== want.rsize)
                    report($sformatf("rounded_size %0h, want %0h (id %0h)",
                                     out_ch.rounded_size, want.rsize, want.id));
                if (out_ch.end_of_list !== want.eol)
                    report($sformatf("end_of_list %0b, want %0b (id %0h)",
                                     out_ch.end_of_list, want.eol, want.id));
            end
        end
    end

    // Watchdog: end the run after too long without any handshake
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        region_result_t typed_res;
        int             run_no;
        int             phase_end;
        int             sent;
        int             big_runs;
        int             len;
        int             sz_bits;
        int             shift_val;
        bit             steady;
        logic [47:0]    size_val;
        logic [62:0]    time_val;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= rsbs_pkg::CFG_BUDGET;
        cfg_wdata            <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.region_id      <= '0;
        in_ch.region_size    <= '0;
        in_ch.access_time_us <= '0;
        in_ch.final_region   <= 1'b0;
        mismatches    = 0;
        hold_request  = 1'b0;
        tbl_count     = 0;
        cur_budget    = '0;
        cur_online    = 1'b0;
        cur_threshold = '0;
        cur_shift     = rsbs_pkg::PAGE_SHIFT_RST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        plan = {
            // reset settings: zero budget, 4 KiB pages
            last_row(8'h00, 48'd0, 63'd0, 1'b0, 48'd0),
            // largest size aligns past 48 bits and saturates
            last_row(8'hFF, MAX48, MAX63, 1'b0, MAX48),
            cfg_row(rsbs_pkg::CFG_BUDGET, MAX48),
            cfg_row(rsbs_pkg::CFG_PAGE_SHIFT, 48'd0),
            // equal access times keep load order
            region_row(8'h01, 48'd100, 63'd5, 1'b0),
            region_row(8'h02, 48'd200, 63'd5, 1'b0),
            region_row(8'h03, 48'd300, 63'd100, 1'b0),
            region_row(8'h04, 48'd400, 63'd0, 1'b0),
            region_row(8'h05, MAX48, MAX63, 1'b1),
            // halved budget, threshold, widest page
            cfg_row(rsbs_pkg::CFG_ONLINE, 48'd1),
            cfg_row(rsbs_pkg::CFG_THRESHOLD, 48'h1000),
            cfg_row(rsbs_pkg::CFG_PAGE_SHIFT, 48'd31),
            region_row(8'h06, 48'd0, 63'd10, 1'b0),
            region_row(8'h07, 48'h1000, 63'd9, 1'b0),
            region_row(8'h08, 48'd1, 63'd9, 1'b0),
            region_row(8'h09, MAX48, 63'd8, 1'b1),
            cfg_row(rsbs_pkg::CFG_BUDGET, 48'h10000),
            cfg_row(rsbs_pkg::CFG_ONLINE, 48'd0),
            cfg_row(rsbs_pkg::CFG_THRESHOLD, 48'd0),
            cfg_row(rsbs_pkg::CFG_PAGE_SHIFT, 48'd12),
            // zero size fits any nonzero budget
            last_row(8'h5A, 48'd0, 63'd123, 1'b1, 48'd0),
            // aligned size equal to the budget does not fit
            last_row(8'hA5, 48'hFFFF, 63'd1, 1'b0, 48'h10000),
            last_row(8'h3C, 48'hEFFF, 63'd1, 1'b1, 48'h0F000),
            cfg_row(rsbs_pkg::CFG_THRESHOLD, MAX48),
            region_row(8'h11, 48'h100, 63'd7, 1'b0),
            region_row(8'h12, MAX48, 63'd7, 1'b1)
        };

        // Directed table
        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
            begin
                if (k == 0 || plan[k-1].kind != ROW_CFG)
                    hold_until_drained();
                write_reg(plan[k].reg_sel, plan[k].value);
            end
            else
            begin
                send_region(plan[k].id, plan[k].size, plan[k].acc, plan[k].fin, gap_len());
                if (plan[k].typed)
                begin
                    typed_res.id    = plan[k].id;
                    typed_res.sel   = plan[k].t_sel;
                    typed_res.rsize = plan[k].t_rsize;
                    typed_res.eol   = 1'b1;
                    void'(due_results.pop_back());
                    due_results.push_back(typed_res);
                end
            end
        end

        // Random runs, new settings every few runs
        run_no    = 0;
        phase_end = 0;
        sent      = 0;
        big_runs  = 0;
        sz_bits   = 12;
        steady    = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (run_no == phase_end)
            begin
                phase_end = run_no + $urandom_range(2, 5);
                hold_until_drained();
                case ($urandom_range(0, 7))
                    0:       shift_val = 0;
                    1:       shift_val = 31;
                    default: shift_val = $urandom_range(0, 30);
                endcase
                sz_bits = $urandom_range(shift_val + 1, 47);
                steady  = ($urandom_range(0, 3) == 0);
                write_reg(rsbs_pkg::CFG_PAGE_SHIFT, 48'(shift_val));
                case ($urandom_range(0, 5))
                    0:       write_reg(rsbs_pkg::CFG_BUDGET, 48'd0);
                    1:       write_reg(rsbs_pkg::CFG_BUDGET, MAX48);
                    default: write_reg(rsbs_pkg::CFG_BUDGET,
                                       masked48((sz_bits + 3 > 48) ? 48 : sz_bits + 3));
                endcase
                write_reg(rsbs_pkg::CFG_ONLINE, 48'($urandom_range(0, 1)));
                case ($urandom_range(0, 5))
                    0, 1, 2: write_reg(rsbs_pkg::CFG_THRESHOLD, 48'd0);
                    3:       write_reg(rsbs_pkg::CFG_THRESHOLD, MAX48);
                    default: write_reg(rsbs_pkg::CFG_THRESHOLD, masked48(sz_bits));
                endcase
            end

            // fill the table at least once, dropping any loads past the end
            if (run_no == 3 || (run_no > 3 && big_runs < 2 && $urandom_range(0, 19) == 0))
            begin
                len = $urandom_range(MAX_REGIONS, MAX_REGIONS + 4);
                big_runs++;
            end
            else
                len = $urandom_range(1, 10);

            if (run_no == 5)
                hold_request = 1'b1;
            if (run_no == 9)
                hold_until_drained();

            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       size_val = masked48(48);
                    1:       size_val = 48'd0;
                    default: size_val = masked48(sz_bits);
                endcase
                case ($urandom_range(0, 7))
                    0, 1, 2: time_val = 63'($urandom_range(0, 7));
                    3:       time_val = MAX63;
                    4:       time_val = 63'd0;
                    default: time_val = rand63();
                endcase
                send_region(8'($urandom_range(0, 255)), size_val, time_val,
                            k == len - 1, steady ? 0 : gap_len());
            end
            sent += len;
            run_no++;
        end

        // Wait out the last results
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
